[rtl/tkk_pkg.sv]
`default_nettype none

package tkk_pkg;

    localparam int unsigned DEPTH_DEF      = 256;
    localparam int unsigned INDEX_BITS_DEF = 16;
    localparam int unsigned SCORE_BITS_DEF = 32;

    // limit registers and read rank have fixed widths
    localparam int unsigned LIM_W  = 9;
    localparam int unsigned RANK_W = 8;

    // register indexes
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_AT_LEAST  = 2'd1;
    localparam logic [1:0] REG_AT_MOST   = 2'd2;
    localparam logic [1:0] REG_SELF_SIM  = 2'd3;

    // request kinds
    localparam logic REQ_OFFER = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic insert;
        logic rd_mode;
    } tkk_ctl_t;

    // handed from a cell to the next one down the list
    typedef struct packed {
        logic ge;
        logic at_thr;
    } tkk_link_t;

    // group size of the two-level collect tree, about sqrt(depth)
    function automatic int unsigned tkk_grp_size(input int unsigned depth);
        int unsigned lg;
        lg = $clog2(depth);
        return 1 << ((lg + 1) >> 1);
    endfunction

endpackage

`default_nettype wire

[rtl/tkk_cell.sv]
`default_nettype none

module tkk_cell #(
    parameter int unsigned IDX        = 0,
    parameter int unsigned SCORE_BITS = tkk_pkg::SCORE_BITS_DEF,
    parameter int unsigned INDEX_BITS = tkk_pkg::INDEX_BITS_DEF,
    parameter int unsigned CNT_W      = 9,
    parameter int unsigned WORD_W     = 64
) (
    input  logic                          clk,
    input  tkk_pkg::tkk_ctl_t             ctl,
    input  logic signed [SCORE_BITS-1:0]  key,
    input  logic signed [SCORE_BITS-1:0]  thr,
    input  logic        [INDEX_BITS-1:0]  new_query,
    input  logic        [INDEX_BITS-1:0]  new_target,
    input  logic        [CNT_W-1:0]       count,
    input  logic        [CNT_W-1:0]       sel,
    input  tkk_pkg::tkk_link_t            prev_link,
    input  logic signed [SCORE_BITS-1:0]  prev_score,
    input  logic        [INDEX_BITS-1:0]  prev_query,
    input  logic        [INDEX_BITS-1:0]  prev_target,
    output tkk_pkg::tkk_link_t            link,
    output logic signed [SCORE_BITS-1:0]  score_out,
    output logic        [INDEX_BITS-1:0]  query_out,
    output logic        [INDEX_BITS-1:0]  target_out,
    output logic        [WORD_W-1:0]      word
);

    localparam logic [CNT_W-1:0] IDXC  = CNT_W'(IDX);
    localparam int unsigned      PAY_W = SCORE_BITS + 2 * INDEX_BITS;
    localparam int unsigned      FLG_W = 2 * (CNT_W + 1);

    logic signed [SCORE_BITS-1:0] score_reg, score_next;
    logic        [INDEX_BITS-1:0] query_reg, query_next;
    logic        [INDEX_BITS-1:0] target_reg, target_next;
    logic occ;
    logic pos_hot;
    logic thr_hot;

    assign occ         = (IDXC < count);
    assign link.ge     = occ && (score_reg >= key);
    assign link.at_thr = occ && (score_reg >= thr);

    // one-hot edges of the two sorted prefixes
    assign pos_hot = prev_link.ge && !link.ge;
    assign thr_hot = prev_link.at_thr && !link.at_thr;

    always_comb
    begin
        score_next  = score_reg;
        query_next  = query_reg;
        target_next = target_reg;
        if (ctl.insert)
        begin
            if (!prev_link.ge)
            begin
                score_next  = prev_score;
                query_next  = prev_query;
                target_next = prev_target;
            end
            else if (!link.ge)
            begin
                score_next  = key;
                query_next  = new_query;
                target_next = new_target;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg  <= score_next;
        query_reg  <= query_next;
        target_reg <= target_next;
    end

    always_comb
    begin
        word = '0;
        if (ctl.rd_mode)
        begin
            if (sel == IDXC)
            begin
                word[PAY_W-1:0] = {score_reg, query_reg, target_reg};
            end
        end
        else
        begin
            word[FLG_W-1:0] = {pos_hot, {CNT_W{pos_hot}} & IDXC,
                               thr_hot, {CNT_W{thr_hot}} & IDXC};
        end
    end

    assign score_out  = score_reg;
    assign query_out  = query_reg;
    assign target_out = target_reg;

endmodule

`default_nettype wire

[rtl/tkk_or_tree.sv]
`default_nettype none

module tkk_or_tree #(
    parameter int unsigned N = tkk_pkg::DEPTH_DEF,
    parameter int unsigned W = 64,
    parameter int unsigned G = 16
) (
    input  logic                clk,
    input  logic [N-1:0][W-1:0] word_in,
    output logic [W-1:0]        result
);

    localparam int unsigned NGRP = (N + G - 1) / G;
    localparam int unsigned NPAD = NGRP * G;

    logic [NPAD-1:0][W-1:0] pad;
    logic [NGRP-1:0][W-1:0] grp_next;
    logic [NGRP-1:0][W-1:0] grp_reg;
    logic [W-1:0]           result_next;
    logic [W-1:0]           result_reg;

    for (genvar p = 0; p < NPAD; p++)
    begin : g_pad
        if (p < N)
        begin : g_used
            assign pad[p] = word_in[p];
        end
        else
        begin : g_fill
            assign pad[p] = '0;
        end
    end

    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        logic [W-1:0] acc;
        always_comb
        begin
            acc = '0;
            for (int k = 0; k < G; k++)
            begin
                acc = acc | pad[g*G + k];
            end
        end
        assign grp_next[g] = acc;
    end

    always_comb
    begin
        result_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            result_next = result_next | grp_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg    <= grp_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/top_k_score_keeper.sv]
`default_nettype none

// Sorted top-k list of match scores, best first, held in a row of cells that
// shift down by one on an insert. A request is taken when start is high and
// busy is low; its result appears on the output ports for exactly one cycle
// with done high, and cannot be held off. A read, or an offer that is
// skipped, gives done after the scan, wait and calc states; an offer that
// is not skipped passes tsel, twait and tdone as well. busy drops in
// the cycle that done is high, so the next request may be taken there. The
// states wait on the registered two-level OR tree that collects the cells'
// answers: one pass finds the insert point and the threshold edge, a
// second pass fetches the new tail score. Configuration writes take effect
// at once and never prune the list by themselves.
module top_k_score_keeper #(
    parameter int unsigned LIST_DEPTH = tkk_pkg::DEPTH_DEF,
    parameter int unsigned INDEX_BITS = tkk_pkg::INDEX_BITS_DEF,
    parameter int unsigned SCORE_BITS = tkk_pkg::SCORE_BITS_DEF,
    localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1),
    localparam int unsigned CFG_W = (SCORE_BITS > tkk_pkg::LIM_W) ?
                                    SCORE_BITS : tkk_pkg::LIM_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [CFG_W-1:0]                  cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic signed [SCORE_BITS-1:0]      score,
    input  logic [INDEX_BITS-1:0]             query_index,
    input  logic [INDEX_BITS-1:0]             target_index,
    input  logic [tkk_pkg::RANK_W-1:0]        read_rank,
    output logic                              done,
    output logic                              accepted,
    output logic [CNT_W-1:0]                  list_count,
    output logic signed [SCORE_BITS-1:0]      tail_score,
    output logic                              entry_valid,
    output logic signed [SCORE_BITS-1:0]      entry_score,
    output logic [INDEX_BITS-1:0]             entry_query,
    output logic [INDEX_BITS-1:0]             entry_target
);

    localparam int unsigned LIM_W  = tkk_pkg::LIM_W;
    localparam int unsigned CNT2_W = $clog2(LIST_DEPTH + 2);
    localparam int unsigned CMP_W  = (CNT2_W > LIM_W) ? CNT2_W : LIM_W;
    localparam int unsigned PAY_W  = SCORE_BITS + 2 * INDEX_BITS;
    localparam int unsigned FLG_W  = 2 * (CNT_W + 1);
    localparam int unsigned WORD_W = (PAY_W > FLG_W) ? PAY_W : FLG_W;
    localparam int unsigned GRP    = tkk_pkg::tkk_grp_size(LIST_DEPTH);

    localparam logic signed [SCORE_BITS-1:0] SCORE_MIN =
        {1'b1, {(SCORE_BITS-1){1'b0}}};
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(LIST_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_CALC  = 3'd3;
    localparam logic [2:0] ST_TSEL  = 3'd4;
    localparam logic [2:0] ST_TWAIT = 3'd5;
    localparam logic [2:0] ST_TDONE = 3'd6;

    // configuration
    logic signed [SCORE_BITS-1:0] thr_reg;
    logic [LIM_W-1:0]             at_least_reg;
    logic [LIM_W-1:0]             at_most_reg;
    logic                         self_sim_reg;

    // control
    logic [2:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic signed [SCORE_BITS-1:0] tail_reg, tail_next;
    logic                         acc_reg, acc_next;
    logic                         done_reg, done_next;

    // request latch
    logic                         req_type_reg;
    logic signed [SCORE_BITS-1:0] key_reg;
    logic [INDEX_BITS-1:0]        query_reg;
    logic [INDEX_BITS-1:0]        target_reg;
    logic [tkk_pkg::RANK_W-1:0]   rank_reg;

    // result registers
    logic                         accepted_reg;
    logic [CNT_W-1:0]             list_count_reg;
    logic signed [SCORE_BITS-1:0] tail_score_reg;
    logic                         entry_valid_reg;
    logic signed [SCORE_BITS-1:0] entry_score_reg;
    logic [INDEX_BITS-1:0]        entry_query_reg;
    logic [INDEX_BITS-1:0]        entry_target_reg;

    tkk_pkg::tkk_ctl_t            ctl;
    logic [CNT_W-1:0]             sel;
    logic                         take;

    tkk_pkg::tkk_link_t           links [LIST_DEPTH];
    logic signed [SCORE_BITS-1:0] chain_score [LIST_DEPTH];
    logic [INDEX_BITS-1:0]        chain_query [LIST_DEPTH];
    logic [INDEX_BITS-1:0]        chain_target [LIST_DEPTH];
    logic [LIST_DEPTH-1:0][WORD_W-1:0] words;
    logic [WORD_W-1:0]            tree_res;

    logic signed [SCORE_BITS-1:0] tr_score;
    logic [INDEX_BITS-1:0]        tr_query;
    logic [INDEX_BITS-1:0]        tr_target;
    logic                         pos_hit;
    logic [CNT_W-1:0]             pos_idx;
    logic                         thr_hit;
    logic [CNT_W-1:0]             thr_idx;

    logic [CMP_W-1:0] pos, tot, total1, n_old, n1, most, t2, al, lo, final_cnt;
    logic             skip, ins, kge, accept, rd_valid;

    assign take = start && !busy;
    assign busy = (state_reg != ST_IDLE);

    // cell row
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        tkk_pkg::tkk_link_t           prev_link;
        logic signed [SCORE_BITS-1:0] prev_score;
        logic [INDEX_BITS-1:0]        prev_query;
        logic [INDEX_BITS-1:0]        prev_target;

        if (i == 0)
        begin : g_head
            assign prev_link.ge     = 1'b1;
            assign prev_link.at_thr = 1'b1;
            assign prev_score       = key_reg;
            assign prev_query       = query_reg;
            assign prev_target      = target_reg;
        end
        else
        begin : g_body
            assign prev_link   = links[i-1];
            assign prev_score  = chain_score[i-1];
            assign prev_query  = chain_query[i-1];
            assign prev_target = chain_target[i-1];
        end

        tkk_cell #(
            .IDX        (i),
            .SCORE_BITS (SCORE_BITS),
            .INDEX_BITS (INDEX_BITS),
            .CNT_W      (CNT_W),
            .WORD_W     (WORD_W)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .key         (key_reg),
            .thr         (thr_reg),
            .new_query   (query_reg),
            .new_target  (target_reg),
            .count       (count_reg),
            .sel         (sel),
            .prev_link   (prev_link),
            .prev_score  (prev_score),
            .prev_query  (prev_query),
            .prev_target (prev_target),
            .link        (links[i]),
            .score_out   (chain_score[i]),
            .query_out   (chain_query[i]),
            .target_out  (chain_target[i]),
            .word        (words[i])
        );
    end

    tkk_or_tree #(
        .N (LIST_DEPTH),
        .W (WORD_W),
        .G (GRP)
    ) u_tree (
        .clk     (clk),
        .word_in (words),
        .result  (tree_res)
    );

    assign tr_score  = $signed(tree_res[PAY_W-1 -: SCORE_BITS]);
    assign tr_query  = tree_res[2*INDEX_BITS-1 -: INDEX_BITS];
    assign tr_target = tree_res[INDEX_BITS-1:0];
    assign pos_hit   = tree_res[FLG_W-1];
    assign pos_idx   = tree_res[FLG_W-2 -: CNT_W];
    assign thr_hit   = tree_res[CNT_W];
    assign thr_idx   = tree_res[CNT_W-1:0];

    // list length arithmetic for an offer, and the rank check for a read
    always_comb
    begin
        tot  = CMP_W'(count_reg);
        al   = CMP_W'(at_least_reg);
        kge  = (key_reg >= thr_reg);
        skip = (self_sim_reg && (query_reg <= target_reg)) ||
               (!kge && (key_reg <= tail_reg) && (tot >= al));

        pos = pos_hit ? CMP_W'(pos_idx) : DEPTH_C;
        ins = (pos < DEPTH_C);
        if (!ins)
            total1 = tot;
        else if (tot < DEPTH_C)
            total1 = tot + CMP_W'(1);
        else
            total1 = DEPTH_C;

        n_old = thr_hit ? CMP_W'(thr_idx) : DEPTH_C;
        n1    = n_old + CMP_W'(ins && kge);
        if (n1 > total1)
            n1 = total1;

        most = CMP_W'(at_most_reg);
        if (most == '0)
            most = CMP_W'(1);
        if (most > DEPTH_C)
            most = DEPTH_C;

        t2 = (total1 < most) ? total1 : most;
        lo = (n1 > al) ? n1 : al;
        if (t2 > al)
            final_cnt = (lo < t2) ? lo : t2;
        else
            final_cnt = t2;

        accept   = (pos < final_cnt);
        rd_valid = (CMP_W'(rank_reg) < tot);
    end

    // sequencer
    always_comb
    begin
        ctl.insert  = 1'b0;
        ctl.rd_mode = req_type_reg;
        sel         = CNT_W'(rank_reg);
        state_next  = state_reg;
        count_next  = count_reg;
        tail_next   = tail_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if ((req_type_reg == tkk_pkg::REQ_READ) || skip)
                begin
                    acc_next   = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.insert = 1'b1;
                    count_next = CNT_W'(final_cnt);
                    acc_next   = accept;
                    state_next = ST_TSEL;
                end
            end
            ST_TSEL:
            begin
                ctl.rd_mode = 1'b1;
                sel         = count_reg - CNT_W'(1);
                state_next  = ST_TWAIT;
            end
            ST_TWAIT:
            begin
                state_next = ST_TDONE;
            end
            ST_TDONE:
            begin
                tail_next  = (count_reg == '0) ? SCORE_MIN : tr_score;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            tail_reg     <= SCORE_MIN;
            acc_reg      <= 1'b0;
            done_reg     <= 1'b0;
            thr_reg      <= SCORE_MIN;
            at_least_reg <= LIM_W'(1);
            at_most_reg  <= LIM_W'(256);
            self_sim_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            tail_reg  <= tail_next;
            acc_reg   <= acc_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tkk_pkg::REG_THRESHOLD: thr_reg <= $signed(cfg_data[SCORE_BITS-1:0]);
                    tkk_pkg::REG_AT_LEAST:  at_least_reg <= cfg_data[LIM_W-1:0];
                    tkk_pkg::REG_AT_MOST:   at_most_reg  <= cfg_data[LIM_W-1:0];
                    tkk_pkg::REG_SELF_SIM:  self_sim_reg <= cfg_data[0];
                    default:                self_sim_reg <= self_sim_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_type_reg <= req_type;
            key_reg      <= score;
            query_reg    <= query_index;
            target_reg   <= target_index;
            rank_reg     <= read_rank;
        end
        if (done_next)
        begin
            accepted_reg   <= acc_next;
            list_count_reg <= count_next;
            tail_score_reg <= tail_next;
            if ((state_reg == ST_CALC) && (req_type_reg == tkk_pkg::REQ_READ) && rd_valid)
            begin
                entry_valid_reg  <= 1'b1;
                entry_score_reg  <= tr_score;
                entry_query_reg  <= tr_query;
                entry_target_reg <= tr_target;
            end
            else
            begin
                entry_valid_reg  <= 1'b0;
                entry_score_reg  <= '0;
                entry_query_reg  <= '0;
                entry_target_reg <= '0;
            end
        end
    end

    assign done         = done_reg;
    assign accepted     = accepted_reg;
    assign list_count   = list_count_reg;
    assign tail_score   = tail_score_reg;
    assign entry_valid  = entry_valid_reg;
    assign entry_score  = entry_score_reg;
    assign entry_query  = entry_query_reg;
    assign entry_target = entry_target_reg;

`ifndef ASSERT_OFF
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> busy && !done)
        else $error("request taken but block not busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("list count beyond depth");

    a_read_keeps_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) && (req_type_reg == tkk_pkg::REQ_READ) |=>
        (count_reg == $past(count_reg)))
        else $error("read request changed the list");

    a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
        done && (list_count == '0) |-> (tail_score == SCORE_MIN))
        else $error("empty list with a tail score");
`endif

endmodule

`default_nettype wire

[test/top_k_score_keeper_tb.sv]
`default_nettype none

module top_k_score_keeper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH  = tkk_pkg::DEPTH_DEF;
    localparam int unsigned IW     = tkk_pkg::INDEX_BITS_DEF;
    localparam int unsigned SW     = tkk_pkg::SCORE_BITS_DEF;
    localparam int unsigned LIM_W  = tkk_pkg::LIM_W;
    localparam int unsigned RANK_W = tkk_pkg::RANK_W;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned CFG_W  = (SW > LIM_W) ? SW : LIM_W;
    localparam int unsigned LIMIT  = 300000;

    localparam logic [1:0] REG_THRESHOLD = tkk_pkg::REG_THRESHOLD;
    localparam logic [1:0] REG_AT_LEAST  = tkk_pkg::REG_AT_LEAST;
    localparam logic [1:0] REG_AT_MOST   = tkk_pkg::REG_AT_MOST;
    localparam logic [1:0] REG_SELF_SIM  = tkk_pkg::REG_SELF_SIM;

    localparam logic REQ_OFFER = tkk_pkg::REQ_OFFER;
    localparam logic REQ_READ  = tkk_pkg::REQ_READ;

    localparam logic signed [SW-1:0] SCORE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] SCORE_MAX = ~SCORE_MIN;
    localparam logic signed [SW-1:0] ONE_Q16   = 1 << 16;

    typedef struct packed {
        logic                 kind;
        logic signed [SW-1:0] score;
        logic [IW-1:0]        query;
        logic [IW-1:0]        target;
        logic [RANK_W-1:0]    rank;
    } score_request_t;

    typedef struct packed {
        logic                 accepted;
        logic [CNT_W-1:0]     list_count;
        logic signed [SW-1:0] tail_score;
        logic                 entry_valid;
        logic signed [SW-1:0] entry_score;
        logic [IW-1:0]        entry_query;
        logic [IW-1:0]        entry_target;
    } list_result_t;

    class topk_scoreboard;
        logic signed [SW-1:0] kept_score [DEPTH];
        logic [IW-1:0]        kept_query [DEPTH];
        logic [IW-1:0]        kept_target [DEPTH];
        int unsigned          held;
        logic signed [SW-1:0] tail;
        logic signed [SW-1:0] threshold;
        int unsigned          at_least;
        int unsigned          at_most;
        logic                 self_sim;
        list_result_t         waiting [$];
        int unsigned          errors;

        function new();
            held      = 0;
            tail      = SCORE_MIN;
            threshold = SCORE_MIN;
            at_least  = 1;
            at_most   = 256;
            self_sim  = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
            case (idx)
                REG_THRESHOLD: threshold = data[SW-1:0];
                REG_AT_LEAST:  at_least  = 32'(data[LIM_W-1:0]);
                REG_AT_MOST:   at_most   = 32'(data[LIM_W-1:0]);
                REG_SELF_SIM:  self_sim  = data[0];
                default:       ;
            endcase
        endfunction

        function void note_request(input score_request_t r);
            list_result_t res;
            int unsigned  most;
            int unsigned  pos;
            int unsigned  total;
            int unsigned  top;
            int unsigned  i;
            logic         skip;
            res = '0;
            if (r.kind == REQ_READ)
            begin
                if (r.rank < held)
                begin
                    res.entry_valid  = 1'b1;
                    res.entry_score  = kept_score[r.rank];
                    res.entry_query  = kept_query[r.rank];
                    res.entry_target = kept_target[r.rank];
                end
            end
            else
            begin
                skip = (self_sim && (r.query <= r.target)) ||
                       ((r.score < threshold) && (r.score <= tail) && (held >= at_least));
                if (!skip)
                begin
                    most = (at_most < 1) ? 1 : ((at_most > DEPTH) ? DEPTH : at_most);
                    pos = 0;
                    while (pos < held && kept_score[pos] >= r.score)
                        pos++;
                    total = held;
                    if (pos < DEPTH)
                    begin
                        top = (total < DEPTH) ? total : DEPTH - 1;
                        for (i = top; i > pos; i--)
                        begin
                            kept_score[i]  = kept_score[i-1];
                            kept_query[i]  = kept_query[i-1];
                            kept_target[i] = kept_target[i-1];
                        end
                        kept_score[pos]  = r.score;
                        kept_query[pos]  = r.query;
                        kept_target[pos] = r.target;
                        if (total < DEPTH)
                            total++;
                    end
                    if (total > most)
                        total = most;
                    while (total > at_least && kept_score[total-1] < threshold)
                        total--;
                    held = total;
                    tail = (total > 0) ? kept_score[total-1] : SCORE_MIN;
                    res.accepted = (pos < total);
                end
            end
            res.list_count = CNT_W'(held);
            res.tail_score = tail;
            waiting.push_back(res);
        endfunction

        function void compare_field(input string name, input logic [SW-1:0] want,
                                    input logic [SW-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(input list_result_t got);
            list_result_t want;
            if (waiting.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request outstanding, expected none, got %0h",
                         $time, got);
                return;
            end
            want = waiting.pop_front();
            compare_field("accepted", SW'(want.accepted), SW'(got.accepted));
            compare_field("list_count", SW'(want.list_count), SW'(got.list_count));
            compare_field("tail_score", want.tail_score, got.tail_score);
            compare_field("entry_valid", SW'(want.entry_valid), SW'(got.entry_valid));
            compare_field("entry_score", want.entry_score, got.entry_score);
            compare_field("entry_query", SW'(want.entry_query), SW'(got.entry_query));
            compare_field("entry_target", SW'(want.entry_target), SW'(got.entry_target));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 start;
    logic                 busy;
    logic                 req_type;
    logic signed [SW-1:0] score;
    logic [IW-1:0]        query_index;
    logic [IW-1:0]        target_index;
    logic [RANK_W-1:0]    read_rank;
    logic                 done;
    logic                 accepted;
    logic [CNT_W-1:0]     list_count;
    logic signed [SW-1:0] tail_score;
    logic                 entry_valid;
    logic signed [SW-1:0] entry_score;
    logic [IW-1:0]        entry_query;
    logic [IW-1:0]        entry_target;

    topk_scoreboard sb;
    int unsigned    cycles = 0;

    top_k_score_keeper dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .score        (score),
        .query_index  (query_index),
        .target_index (target_index),
        .read_rank    (read_rank),
        .done         (done),
        .accepted     (accepted),
        .list_count   (list_count),
        .tail_score   (tail_score),
        .entry_valid  (entry_valid),
        .entry_score  (entry_score),
        .entry_query  (entry_query),
        .entry_target (entry_target)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_request(score_request_t'{req_type, score, query_index,
                                                 target_index, read_rank});
            if (done)
                sb.check_result(list_result_t'{accepted, list_count, tail_score,
                                               entry_valid, entry_score, entry_query,
                                               entry_target});
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input logic kind, input logic signed [SW-1:0] sc,
                                input logic [IW-1:0] q, input logic [IW-1:0] t,
                                input logic [RANK_W-1:0] rank);
        @(negedge clk);
        start        = 1'b1;
        req_type     = kind;
        score        = sc;
        query_index  = q;
        target_index = t;
        read_rank    = rank;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic pause(input int unsigned n);
        if (n == 0)
            return;
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic offer(input logic signed [SW-1:0] sc, input logic [IW-1:0] q,
                         input logic [IW-1:0] t);
        send_request(REQ_OFFER, sc, q, t, RANK_W'($urandom));
        pause(pick_gap());
    endtask

    task automatic read_entry(input logic [RANK_W-1:0] rank);
        send_request(REQ_READ, SW'($urandom), IW'($urandom), IW'($urandom), rank);
        pause(pick_gap());
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.waiting.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic random_item();
        logic signed [SW-1:0] sc;
        logic [IW-1:0]        q;
        logic [IW-1:0]        t;
        int unsigned          lim;
        if ($urandom_range(0, 99) < 30)
        begin
            lim = (sb.held + 1 > 255) ? 255 : sb.held + 1;
            if ($urandom_range(0, 99) < 70)
                read_entry(RANK_W'($urandom_range(0, lim)));
            else
                read_entry(RANK_W'($urandom));
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:       sc = (int'($urandom_range(0, 15)) - 8) * (1 << 16);
                1:       sc = $urandom;
                2:       sc = sb.threshold + $urandom_range(0, 6) - 3;
                3:       sc = $urandom_range(0, 1) ? SCORE_MAX : SCORE_MIN;
                default: sc = sb.tail + $urandom_range(0, 4) - 2;
            endcase
            if ($urandom_range(0, 1))
            begin
                q = IW'($urandom);
                t = IW'($urandom);
            end
            else
            begin
                q = IW'($urandom_range(0, 7));
                t = IW'($urandom_range(0, 7));
            end
            offer(sc, q, t);
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return CFG_W'(SCORE_MIN);
            1:       return CFG_W'(SCORE_MAX);
            2:       return '0;
            3:       return $urandom;
            default: return CFG_W'((int'($urandom_range(0, 9)) - 5) * (1 << 16));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_at_least();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return 1;
            2:       return 256;
            3:       return 511;
            4:       return $urandom_range(0, 511);
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_at_most();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return 1;
            2:       return 256;
            3:       return $urandom_range(257, 511);
            4:       return $urandom_range(1, 256);
            default: return $urandom_range(2, 16);
        endcase
    endfunction

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        start        = 1'b0;
        req_type     = REQ_OFFER;
        score        = '0;
        query_index  = '0;
        target_index = '0;
        read_rank    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list, then extremes and a tie
        read_entry(0);
        read_entry(255);
        offer(SCORE_MAX, 16'hFFFF, 16'h0000);
        offer(SCORE_MIN, 16'h0000, 16'hFFFF);
        offer(0, 1, 2);
        offer(0, 3, 4);
        read_entry(1);
        read_entry(2);
        read_entry(3);
        read_entry(4);

        // self-similar skip
        write_reg(REG_SELF_SIM, 1);
        offer(5 * ONE_Q16, 7, 7);
        offer(5 * ONE_Q16, 6, 7);
        offer(5 * ONE_Q16, 8, 7);
        write_reg(REG_SELF_SIM, 0);

        // threshold pruning and skip below tail
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_AT_LEAST, 2);
        offer(-ONE_Q16, 9, 9);
        offer(SCORE_MIN, 10, 10);

        // limit changes do not prune until the next insert
        write_reg(REG_AT_MOST, 1);
        read_entry(3);
        offer(ONE_Q16, 11, 11);
        write_reg(REG_AT_MOST, 0);
        offer(SCORE_MAX, 12, 1);
        write_reg(REG_AT_MOST, 511);
        offer(2 * ONE_Q16, 13, 2);
        read_entry(1);
        write_reg(REG_AT_LEAST, 256);
        write_reg(REG_THRESHOLD, CFG_W'(SCORE_MAX));
        offer(SCORE_MIN, 14, 3);
        read_entry(2);

        // fill past the depth, then offer below every entry of a full list
        write_reg(REG_THRESHOLD, CFG_W'(SCORE_MIN));
        write_reg(REG_AT_LEAST, 1);
        write_reg(REG_AT_MOST, 256);
        repeat (262) offer($urandom, IW'($urandom), IW'($urandom));
        offer(SCORE_MIN, 16'h1234, 16'h4321);
        read_entry(255);

        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 0)
            begin
                write_reg(REG_THRESHOLD, CFG_W'(SCORE_MAX));
                write_reg(REG_AT_LEAST, 511);
                write_reg(REG_AT_MOST, 511);
                write_reg(REG_SELF_SIM, 1);
            end
            else if (ph == 1)
            begin
                write_reg(REG_THRESHOLD, CFG_W'(SCORE_MIN));
                write_reg(REG_AT_LEAST, 0);
                write_reg(REG_AT_MOST, 1);
                write_reg(REG_SELF_SIM, 0);
            end
            else
            begin
                write_reg(REG_THRESHOLD, pick_threshold());
                write_reg(REG_AT_LEAST, pick_at_least());
                write_reg(REG_AT_MOST, pick_at_most());
                write_reg(REG_SELF_SIM, $urandom_range(0, 1));
            end
            repeat (95) random_item();
        end

        drain();
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.waiting.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            if (sb.waiting.size() != 0)
                $display("%0t: results missing, expected %0d more, got 0",
                         $time, sb.waiting.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
